/* sv/wpfc_pkg.sv */
`default_nettype none
package wpfc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_KP_FORWARD   = 3'd0;
  localparam logic [2:0] REG_KP_HEADING   = 3'd1;
  localparam logic [2:0] REG_KI_HEADING   = 3'd2;
  localparam logic [2:0] REG_KD_HEADING   = 3'd3;
  localparam logic [2:0] REG_KP_HEIGHT    = 3'd4;
  localparam logic [2:0] REG_KI_HEIGHT    = 3'd5;
  localparam logic [2:0] REG_KD_HEIGHT    = 3'd6;
  localparam logic [2:0] REG_ARRIVE_TOL   = 3'd7;

  localparam logic [1:0] FUNC_GOAL   = 2'd0;
  localparam logic [1:0] FUNC_POSE   = 2'd1;
  localparam logic [1:0] FUNC_ENABLE = 2'd2;

  localparam logic [1:0] PHASE_TURN = 2'd0;
  localparam logic [1:0] PHASE_MOVE = 2'd1;
  localparam logic [1:0] PHASE_HOLD = 2'd2;

  localparam logic [1:0] CH_FWD  = 2'd0;
  localparam logic [1:0] CH_HEAD = 2'd1;
  localparam logic [1:0] CH_HGT  = 2'd2;

  typedef struct packed {
    logic [23:0] kp_forward;
    logic [23:0] kp_heading;
    logic [23:0] ki_heading_scaled;
    logic [23:0] kd_heading_scaled;
    logic [23:0] kp_height;
    logic [23:0] ki_height_scaled;
    logic [23:0] kd_height_scaled;
    logic [15:0] arrive_tolerance;
  } wpfc_cfg_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/wpfc_regs.sv */
`default_nettype none
module wpfc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [wpfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [wpfc_pkg::DATA_W-1:0] pwdata,
  output logic      [wpfc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output wpfc_pkg::wpfc_cfg_t             cfg
);
  import wpfc_pkg::*;

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_forward        <= 24'd32768;
      cfg.kp_heading        <= 24'd13107;
      cfg.ki_heading_scaled <= 24'd52;
      cfg.kd_heading_scaled <= 24'd131072;
      cfg.kp_height         <= 24'd65536;
      cfg.ki_height_scaled  <= 24'd262;
      cfg.kd_height_scaled  <= 24'd655360;
      cfg.arrive_tolerance  <= 16'd51;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_KP_FORWARD: cfg.kp_forward        <= pwdata[23:0];
        REG_KP_HEADING: cfg.kp_heading        <= pwdata[23:0];
        REG_KI_HEADING: cfg.ki_heading_scaled <= pwdata[23:0];
        REG_KD_HEADING: cfg.kd_heading_scaled <= pwdata[23:0];
        REG_KP_HEIGHT:  cfg.kp_height         <= pwdata[23:0];
        REG_KI_HEIGHT:  cfg.ki_height_scaled  <= pwdata[23:0];
        REG_KD_HEIGHT:  cfg.kd_height_scaled  <= pwdata[23:0];
        REG_ARRIVE_TOL: cfg.arrive_tolerance  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP_FORWARD: prdata = {8'd0, cfg.kp_forward};
      REG_KP_HEADING: prdata = {8'd0, cfg.kp_heading};
      REG_KI_HEADING: prdata = {8'd0, cfg.ki_heading_scaled};
      REG_KD_HEADING: prdata = {8'd0, cfg.kd_heading_scaled};
      REG_KP_HEIGHT:  prdata = {8'd0, cfg.kp_height};
      REG_KI_HEIGHT:  prdata = {8'd0, cfg.ki_height_scaled};
      REG_KD_HEIGHT:  prdata = {8'd0, cfg.kd_height_scaled};
      REG_ARRIVE_TOL: prdata = {16'd0, cfg.arrive_tolerance};
    endcase
  end

endmodule
`default_nettype wire

/* sv/waypoint_pid_flight_controller.sv */
// Waypoint flight controller. Goal and enable beats are taken in the idle state and give
// no result. An enabled pose beat gives one result: the sequencer drives one shared 34x26
// multiplier for the yaw conversion, the squared distances and every PID term, runs
// CORDIC_STEPS vectoring steps for the bearing at one step per cycle, and takes the
// planar distance by a 26-step square root. in_stall stays high for the whole tick; a
// finished result waits in the output register while the next beat is accepted.
`default_nettype none
module waypoint_pid_flight_controller (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic signed [23:0]          pos_x,
  input  wire logic signed [23:0]          pos_y,
  input  wire logic signed [23:0]          pos_z,
  input  wire logic signed [15:0]          yaw_raw,
  input  wire logic                        enable_flag,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [15:0]               forward_speed,
  output logic signed [15:0]               climb_speed,
  output logic signed [15:0]               turn_rate,
  output logic                             goal_reached_pulse,
  output logic [1:0]                       phase,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wpfc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [wpfc_pkg::DATA_W-1:0] pwdata,
  output logic      [wpfc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import wpfc_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_YAW   = 5'd1;
  localparam logic [4:0] ST_HDG   = 5'd2;
  localparam logic [4:0] ST_SQY   = 5'd3;
  localparam logic [4:0] ST_SQZ   = 5'd4;
  localparam logic [4:0] ST_TOLSQ = 5'd5;
  localparam logic [4:0] ST_FAR   = 5'd6;
  localparam logic [4:0] ST_CINIT = 5'd7;
  localparam logic [4:0] ST_CSTEP = 5'd8;
  localparam logic [4:0] ST_CDONE = 5'd9;
  localparam logic [4:0] ST_DEC   = 5'd10;
  localparam logic [4:0] ST_SQRT  = 5'd11;
  localparam logic [4:0] ST_PSEL  = 5'd12;
  localparam logic [4:0] ST_PSET  = 5'd13;
  localparam logic [4:0] ST_PM0   = 5'd14;
  localparam logic [4:0] ST_PM1   = 5'd15;
  localparam logic [4:0] ST_PM2   = 5'd16;
  localparam logic [4:0] ST_PFIN  = 5'd17;
  localparam logic [4:0] ST_EMIT  = 5'd18;

  localparam logic [4:0] CI_LAST = 5'(CORDIC_ITERS - 1);

  wpfc_cfg_t cfg;

  wpfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [4:0] state;

  logic signed [23:0] goal_x, goal_y, goal_z, cur_x, cur_y, cur_z;
  logic [15:0] heading;
  logic enabled, goal_pending, turning, goal_reported;
  logic signed [31:0] prev_err [3];
  logic signed [31:0] int_sum [3];

  logic [16:0] yaw_adj;
  logic signed [24:0] dx, dy, dz;
  logic [51:0] sq_acc, planar_sq, dist3;
  logic far;

  logic signed [59:0] cx, cy;
  logic signed [31:0] cz;
  logic [4:0] ci;
  logic bzero;
  logic signed [17:0] herr;

  logic [51:0] sq_n, sq_res, sq_bit;

  logic [2:0] mask;
  logic [1:0] ch;
  logic signed [31:0] pe, pinteg;
  logic signed [32:0] pdiff;
  logic signed [63:0] acc;

  logic signed [15:0] r_fwd, r_climb, r_turn;
  logic r_pulse;
  logic [1:0] r_phase;

  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] prod;

  // combinational helpers
  logic [59:0] yaw_rnd;
  logic [15:0] deg;
  logic [15:0] heading_next;
  logic signed [59:0] cxs, cys, cx0, cy0;
  logic signed [31:0] atan_ext, zr, q, bear_q;
  logic signed [17:0] bear, hc, hdiff, herr_next;
  logic [51:0] sq_try;
  logic [23:0] kp_sel, ki_sel, kd_sel;
  logic signed [32:0] imax, integ33, prev_ext;
  logic signed [31:0] integ_clamped;
  logic signed [63:0] sum, rsum, shifted;
  logic signed [15:0] sat;
  logic can_emit;

  assign in_stall = (state != ST_IDLE);
  assign can_emit = !out_valid || !out_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_YAW: begin
        mul_a = {17'd0, yaw_adj};
        mul_b = 26'sd3754937;
      end
      ST_HDG: begin
        mul_a = {{9{dx[24]}}, dx};
        mul_b = {dx[24], dx};
      end
      ST_SQY: begin
        mul_a = {{9{dy[24]}}, dy};
        mul_b = {dy[24], dy};
      end
      ST_SQZ: begin
        mul_a = {{9{dz[24]}}, dz};
        mul_b = {dz[24], dz};
      end
      ST_TOLSQ: begin
        mul_a = {18'd0, cfg.arrive_tolerance};
        mul_b = {10'd0, cfg.arrive_tolerance};
      end
      ST_PM0: begin
        mul_a = {{2{pe[31]}}, pe};
        mul_b = {2'd0, kp_sel};
      end
      ST_PM1: begin
        mul_a = {{2{pinteg[31]}}, pinteg};
        mul_b = {2'd0, ki_sel};
      end
      ST_PM2: begin
        mul_a = {pdiff[32], pdiff};
        mul_b = {2'd0, kd_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 60'(mul_a * mul_b);
  end

  always_comb begin
    yaw_rnd = prod + 60'd2097152;
    deg = yaw_rnd[37:22];
    heading_next = (deg < 16'd11520) ? 16'd11520 - deg : 16'd57600 - deg;

    cxs = cx >>> ci;
    cys = cy >>> ci;
    atan_ext = {10'd0, atan_q16(ci)};
    cx0 = {{3{dy[24]}}, dy, 32'd0};
    cy0 = {{3{dx[24]}}, dx, 32'd0};

    zr = cz + 32'sd256;
    q = zr >>> 9;
    bear_q = (q < 0) ? q + 32'sd46080 : q;
    bear = bzero ? 18'sd0 : bear_q[17:0];
    hc = {2'd0, heading};
    if (hc < bear) begin
      hdiff = bear - hc;
      herr_next = (hdiff > 18'sd23040) ? 18'sd46080 - hdiff : hc - bear;
    end else begin
      hdiff = hc - bear;
      herr_next = (hdiff < 18'sd23040) ? hdiff : hdiff - 18'sd46080;
    end

    sq_try = sq_res + sq_bit;

    case (ch)
      CH_FWD: begin
        kp_sel = cfg.kp_forward;
        ki_sel = '0;
        kd_sel = '0;
        imax = 33'sd1280;
      end
      CH_HEAD: begin
        kp_sel = cfg.kp_heading;
        ki_sel = cfg.ki_heading_scaled;
        kd_sel = cfg.kd_heading_scaled;
        imax = 33'sd128;
      end
      default: begin
        kp_sel = cfg.kp_height;
        ki_sel = cfg.ki_height_scaled;
        kd_sel = cfg.kd_height_scaled;
        imax = 33'sd51;
      end
    endcase

    integ33 = {int_sum[ch][31], int_sum[ch]} + {pe[31], pe};
    prev_ext = {prev_err[ch][31], prev_err[ch]};
    priority if (integ33 > imax) integ_clamped = imax[31:0];
    else if (integ33 < -33'sd2147483648) integ_clamped = 32'h8000_0000;
    else integ_clamped = integ33[31:0];

    sum = acc + {{4{prod[59]}}, prod};
    if (ch == CH_HEAD) begin
      rsum = sum + 64'sd16384;
      shifted = rsum >>> 15;
    end else begin
      rsum = sum + 64'sd32768;
      shifted = rsum >>> 16;
    end
    priority if (shifted > 64'sd32767) sat = 16'sh7fff;
    else if (shifted < -64'sd32768) sat = 16'sh8000;
    else sat = shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      enabled       <= 1'b1;
      goal_pending  <= 1'b0;
      turning       <= 1'b0;
      goal_reported <= 1'b0;
      goal_x        <= '0;
      goal_y        <= '0;
      goal_z        <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      cur_z         <= '0;
      heading       <= '0;
      for (int k = 0; k < 3; k++) begin
        prev_err[k] <= '0;
        int_sum[k]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != ST_EMIT)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (func)
              FUNC_GOAL: begin
                goal_x        <= pos_x;
                goal_y        <= pos_y;
                goal_z        <= pos_z;
                goal_pending  <= 1'b1;
                goal_reported <= 1'b0;
              end
              FUNC_POSE: begin
                cur_x   <= pos_x;
                cur_y   <= pos_y;
                cur_z   <= pos_z;
                yaw_adj <= yaw_raw[15] ? 17'(signed'(yaw_raw) + 32'sd51472)
                                       : {1'b0, yaw_raw};
                state   <= ST_YAW;
              end
              FUNC_ENABLE: begin
                enabled <= enable_flag;
                if (!enable_flag) turning <= 1'b0;
              end
              default: begin
                enabled <= enabled;
              end
            endcase
          end
        end
        ST_YAW: begin
          dx    <= {goal_x[23], goal_x} - {cur_x[23], cur_x};
          dy    <= {goal_y[23], goal_y} - {cur_y[23], cur_y};
          dz    <= {goal_z[23], goal_z} - {cur_z[23], cur_z};
          state <= ST_HDG;
        end
        ST_HDG: begin
          heading <= heading_next;
          if (!enabled) begin
            state <= ST_IDLE;
          end else begin
            if (goal_pending) begin
              goal_pending <= 1'b0;
              turning      <= 1'b1;
            end
            state <= ST_SQY;
          end
        end
        ST_SQY: begin
          sq_acc <= prod[51:0];
          state  <= ST_SQZ;
        end
        ST_SQZ: begin
          planar_sq <= sq_acc + prod[51:0];
          state     <= ST_TOLSQ;
        end
        ST_TOLSQ: begin
          dist3 <= planar_sq + prod[51:0];
          state <= ST_FAR;
        end
        ST_FAR: begin
          far <= dist3 > prod[51:0];
          if (!turning && !(dist3 > prod[51:0])) begin
            r_fwd         <= '0;
            r_climb       <= '0;
            r_turn        <= '0;
            r_pulse       <= !goal_reported;
            r_phase       <= PHASE_HOLD;
            goal_reported <= 1'b1;
            state         <= ST_EMIT;
          end else begin
            state <= ST_CINIT;
          end
        end
        ST_CINIT: begin
          ci    <= '0;
          bzero <= (dx == '0) && (dy == '0);
          if (dy < 0) begin
            cx <= -cx0;
            cy <= -cy0;
            cz <= (dx >= 0) ? 32'sd11796480 : -32'sd11796480;
          end else begin
            cx <= cx0;
            cy <= cy0;
            cz <= '0;
          end
          state <= ((dx == '0) && (dy == '0)) ? ST_CDONE : ST_CSTEP;
        end
        ST_CSTEP: begin
          if (cy >= 0) begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + atan_ext;
          end else begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - atan_ext;
          end
          ci <= ci + 5'd1;
          if (ci == CI_LAST) state <= ST_CDONE;
        end
        ST_CDONE: begin
          herr  <= herr_next;
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (turning && far && ((herr > 18'sd2560) || (herr < -18'sd2560))) begin
            r_fwd   <= '0;
            r_pulse <= 1'b0;
            r_phase <= PHASE_TURN;
            mask    <= 3'b110;
            state   <= ST_PSEL;
          end else begin
            turning <= 1'b0;
            if (far) begin
              r_pulse <= 1'b0;
              r_phase <= PHASE_MOVE;
              mask    <= 3'b111;
              sq_n    <= planar_sq;
              sq_res  <= '0;
              sq_bit  <= 52'd1 << 50;
              state   <= ST_SQRT;
            end else begin
              r_fwd         <= '0;
              r_climb       <= '0;
              r_turn        <= '0;
              r_pulse       <= !goal_reported;
              r_phase       <= PHASE_HOLD;
              goal_reported <= 1'b1;
              state         <= ST_EMIT;
            end
          end
        end
        ST_SQRT: begin
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) state <= ST_PSEL;
        end
        ST_PSEL: begin
          priority if (mask[0]) begin
            ch      <= CH_FWD;
            pe      <= {6'd0, sq_res[25:0]};
            mask[0] <= 1'b0;
            state   <= ST_PSET;
          end else if (mask[2]) begin
            ch      <= CH_HGT;
            pe      <= {{7{dz[24]}}, dz};
            mask[2] <= 1'b0;
            state   <= ST_PSET;
          end else if (mask[1]) begin
            ch      <= CH_HEAD;
            pe      <= {{14{herr[17]}}, herr};
            mask[1] <= 1'b0;
            state   <= ST_PSET;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_PSET: begin
          pinteg       <= integ_clamped;
          pdiff        <= {pe[31], pe} - prev_ext;
          int_sum[ch]  <= integ_clamped;
          prev_err[ch] <= pe;
          state        <= ST_PM0;
        end
        ST_PM0: begin
          state <= ST_PM1;
        end
        ST_PM1: begin
          acc   <= {{4{prod[59]}}, prod};
          state <= ST_PM2;
        end
        ST_PM2: begin
          acc   <= sum;
          state <= ST_PFIN;
        end
        ST_PFIN: begin
          case (ch)
            CH_FWD:  r_fwd   <= sat;
            CH_HEAD: r_turn  <= sat;
            default: r_climb <= sat;
          endcase
          state <= ST_PSEL;
        end
        ST_EMIT: begin
          if (can_emit) begin
            forward_speed      <= r_fwd;
            climb_speed        <= r_climb;
            turn_rate          <= r_turn;
            goal_reached_pulse <= r_pulse;
            phase              <= r_phase;
            out_valid          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpfc_pkg::*;

  typedef struct {
    logic [1:0]         func;
    logic signed [23:0] x, y, z;
    logic signed [15:0] yaw;
    logic               en;
  } beat_t;

  typedef struct {
    logic signed [15:0] fwd, climb, turn;
    logic               pulse;
    logic [1:0]         ph;
  } command_t;

  localparam longint ATAN_TAB [0:31] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1,
    0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int TIMEOUT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_GOAL;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] yaw_raw = '0;
  logic enable_flag = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] forward_speed, climb_speed, turn_rate;
  logic goal_reached_pulse;
  logic [1:0] phase;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  waypoint_pid_flight_controller uut (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  int goal_pos [3];
  int cur_pos [3];
  int heading_q7;
  bit ctl_enabled = 1'b1, goal_pending, turning, goal_reported;
  int prev_err [3];
  int integ [3];
  logic [23:0] gain [8] = '{32768, 13107, 52, 131072, 65536, 262, 655360, 51};

  beat_t    pending_beats [$];
  command_t expected_cmds [$];
  int errors, commands_seen, beats_sent, phase_count [3];
  int cycles;
  bit burst_in, burst_out;
  int in_gap, out_gap;
  bit hold_req, hold_done;
  int hold_cnt;

  function automatic longint sq(longint v);
    return v * v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else res = res >>> 1;
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic int bearing_q7();
    longint dx, dy, x, y, z, xs, ys, q;
    dx = longint'(goal_pos[0]) - cur_pos[0];
    dy = longint'(goal_pos[1]) - cur_pos[1];
    if (dx == 0 && dy == 0) return 0;
    x = dy <<< 32;
    y = dx <<< 32;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    q = (z + 256) >>> 9;
    if (q < 0) q += 46080;
    return int'(q);
  endfunction

  function automatic int heading_error();
    int c, d;
    c = heading_q7;
    d = bearing_q7();
    if (c < d) begin
      if (d - c > 23040) return 46080 - (d - c);
      return c - d;
    end
    if (c - d < 23040) return c - d;
    return c - d - 46080;
  endfunction

  function automatic logic signed [15:0] pid_step(int ch, int e, logic [23:0] kp,
      logic [23:0] ki, logic [23:0] kd, int imax, int shift);
    longint prev, i_sum, acc;
    prev = prev_err[ch];
    i_sum = longint'(integ[ch]) + e;
    prev_err[ch] = e;
    if (i_sum > imax) i_sum = imax;
    if (i_sum < -64'sd2147483648) i_sum = -64'sd2147483648;
    integ[ch] = int'(i_sum);
    acc = longint'(kp) * e + longint'(ki) * i_sum + longint'(kd) * (longint'(e) - prev);
    acc = (acc + (64'sd1 <<< (shift - 1))) >>> shift;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  task automatic track_beat(beat_t b);
    longint raw, deg, dx, dy, dz, tol;
    bit far;
    int he, mag;
    command_t c;
    beats_sent++;
    if (b.func == FUNC_GOAL) begin
      goal_pos = '{int'(b.x), int'(b.y), int'(b.z)};
      goal_pending = 1;
      goal_reported = 0;
      return;
    end
    if (b.func == FUNC_ENABLE) begin
      ctl_enabled = b.en;
      if (!b.en) turning = 0;
      return;
    end
    if (b.func != FUNC_POSE) return;
    cur_pos = '{int'(b.x), int'(b.y), int'(b.z)};
    raw = b.yaw;
    if (raw < 0) raw += 51472;
    deg = (raw * 3754937 + (64'sd1 <<< 21)) >>> 22;
    heading_q7 = int'(deg < 11520 ? 11520 - deg : 57600 - deg);
    if (!ctl_enabled) return;
    if (goal_pending) begin
      goal_pending = 0;
      turning = 1;
    end
    dx = longint'(goal_pos[0]) - cur_pos[0];
    dy = longint'(goal_pos[1]) - cur_pos[1];
    dz = longint'(goal_pos[2]) - cur_pos[2];
    tol = gain[REG_ARRIVE_TOL][15:0];
    far = sq(dx) + sq(dy) + sq(dz) > tol * tol;
    c = '{fwd: '0, climb: '0, turn: '0, pulse: 1'b0, ph: PHASE_HOLD};
    if (turning) begin
      he = heading_error();
      mag = he < 0 ? -he : he;
      if (far && mag > 2560) begin
        c.climb = pid_step(CH_HGT, int'(dz), gain[REG_KP_HEIGHT], gain[REG_KI_HEIGHT],
                           gain[REG_KD_HEIGHT], 51, 16);
        c.turn = pid_step(CH_HEAD, he, gain[REG_KP_HEADING], gain[REG_KI_HEADING],
                          gain[REG_KD_HEADING], 128, 15);
        c.ph = PHASE_TURN;
        expected_cmds.push_back(c);
        return;
      end
      turning = 0;
    end
    if (far) begin
      c.fwd = pid_step(CH_FWD, int'(int_sqrt(sq(dx) + sq(dy))), gain[REG_KP_FORWARD], 0, 0,
                       1280, 16);
      c.climb = pid_step(CH_HGT, int'(dz), gain[REG_KP_HEIGHT], gain[REG_KI_HEIGHT],
                         gain[REG_KD_HEIGHT], 51, 16);
      c.turn = pid_step(CH_HEAD, heading_error(), gain[REG_KP_HEADING], gain[REG_KI_HEADING],
                        gain[REG_KD_HEADING], 128, 15);
      c.ph = PHASE_MOVE;
    end else begin
      c.pulse = !goal_reported;
      goal_reported = 1;
    end
    expected_cmds.push_back(c);
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch on command %0d: %s got %0d expected %0d", commands_seen, field, got,
             want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        track_beat('{func, pos_x, pos_y, pos_z, yaw_raw, enable_flag});
        if ($urandom_range(0, 29) == 0) burst_in = !burst_in;
        in_gap = burst_in ? 0 : $urandom_range(0, 18);
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          b = pending_beats.pop_front();
          func <= b.func;
          pos_x <= b.x;
          pos_y <= b.y;
          pos_z <= b.z;
          yaw_raw <= b.yaw;
          enable_flag <= b.en;
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk) begin
    command_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("unexpected command at cycle %0d", cycles);
          errors++;
        end else begin
          e = expected_cmds.pop_front();
          if (forward_speed !== e.fwd) report("forward_speed", forward_speed, e.fwd);
          if (climb_speed !== e.climb) report("climb_speed", climb_speed, e.climb);
          if (turn_rate !== e.turn) report("turn_rate", turn_rate, e.turn);
          if (goal_reached_pulse !== e.pulse)
            report("goal_reached_pulse", goal_reached_pulse, e.pulse);
          if (phase !== e.ph) report("phase", phase, e.ph);
          if (e.ph <= PHASE_HOLD) phase_count[e.ph]++;
        end
        commands_seen++;
        if ($urandom_range(0, 19) == 0) burst_out = !burst_out;
        out_gap = burst_out ? 0 : $urandom_range(0, 18);
      end
      out_stall <= (hold_cnt > 1) || (out_gap > 0);
      if (out_gap > 0) out_gap--;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gain[idx] = (idx == REG_ARRIVE_TOL) ? {8'd0, val[15:0]} : val;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push(logic [1:0] f, int x, int y, int z, int yaw, bit en);
    pending_beats.push_back('{f, x[23:0], y[23:0], z[23:0], yaw[15:0], en});
  endtask

  function automatic int rand_yaw();
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return int'($urandom_range(0, 51472)) - 25736;
  endfunction

  function automatic int near(int c, int tol);
    case ($urandom_range(0, 4))
      0: return c;
      1: return c + int'($urandom_range(0, 2 * tol + 2)) - tol - 1;
      2: return c + int'($urandom_range(0, 4000)) - 2000;
      3: return c + int'($urandom_range(0, 400000)) - 200000;
      default: return $signed(24'($urandom));
    endcase
  endfunction

  task automatic random_traffic(int n);
    int gx, gy, gz, tol, k;
    tol = gain[REG_ARRIVE_TOL] > 4000 ? 4000 : gain[REG_ARRIVE_TOL];
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 19))
        0: push(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: push(FUNC_ENABLE, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) != 0);
        2: push(FUNC_ENABLE, $urandom, $urandom, $urandom, $urandom, 1'b1);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            gx = $signed(24'($urandom));
            gy = $signed(24'($urandom));
            gz = $signed(24'($urandom));
          end else begin
            gx = int'($urandom_range(0, 200000)) - 100000;
            gy = int'($urandom_range(0, 200000)) - 100000;
            gz = int'($urandom_range(0, 20000)) - 10000;
          end
          push(FUNC_GOAL, gx, gy, gz, $urandom, $urandom);
          repeat ($urandom_range(3, 10)) begin
            push(FUNC_POSE, near(gx, tol), near(gy, tol), near(gz, tol), rand_yaw(),
                 $urandom);
            k++;
          end
        end
      endcase
      k++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push(FUNC_POSE, 0, 0, 0, 0, 0);
    push(2'd3, -1, -1, -1, -1, 1);
    push(FUNC_GOAL, 8388607, -8388608, 8388607, 0, 0);
    push(FUNC_POSE, -8388608, 8388607, -8388608, 32767, 1);
    push(FUNC_POSE, -8388608, 8388607, -8388608, -32768, 0);
    push(FUNC_POSE, 0, 0, 0, 25736, 0);
    push(FUNC_POSE, 0, 0, 0, -25736, 0);
    push(FUNC_ENABLE, 0, 0, 0, 0, 0);
    push(FUNC_POSE, 100, 100, 100, 1000, 0);
    push(FUNC_ENABLE, 0, 0, 0, 0, 1);
    push(FUNC_POSE, 100, 100, 100, 1000, 0);
    push(FUNC_GOAL, 5000, 0, 300, 0, 0);
    push(FUNC_POSE, 0, 0, 0, -12868, 0);
    push(FUNC_POSE, 0, 0, 0, 12868, 0);
    push(FUNC_ENABLE, 0, 0, 0, 0, 0);
    push(FUNC_ENABLE, 0, 0, 0, 0, 1);
    push(FUNC_POSE, 0, 0, 0, 0, 0);
    push(FUNC_POSE, 2000, 0, 200, 12868, 0);
    push(FUNC_POSE, 5000, 0, 300, 12868, 0);
    push(FUNC_POSE, 5000, 0, 320, -1, 0);
    push(FUNC_POSE, 5010, 10, 300, 0, 0);
    push(FUNC_GOAL, 5000, 0, 300, 0, 0);
    push(FUNC_POSE, 5000, 0, 300, 0, 0);
    drain();

    hold_req = 1'b1;
    random_traffic(130);
    drain();

    reg_write(REG_KP_FORWARD, 24'hFFFFFF);
    reg_write(REG_KP_HEADING, 24'hFFFFFF);
    reg_write(REG_KI_HEADING, 24'hFFFFFF);
    reg_write(REG_KD_HEADING, 24'hFFFFFF);
    reg_write(REG_KP_HEIGHT, 24'hFFFFFF);
    reg_write(REG_KI_HEIGHT, 24'hFFFFFF);
    reg_write(REG_KD_HEIGHT, 24'hFFFFFF);
    reg_write(REG_ARRIVE_TOL, 24'h00FFFF);
    random_traffic(120);
    drain();

    for (int r = 0; r < 8; r++) reg_write(r[2:0], 24'd0);
    random_traffic(120);
    drain();

    for (int r = 0; r < 8; r++) reg_write(r[2:0], 24'($urandom) >> $urandom_range(0, 20));
    random_traffic(130);
    drain();

    reg_write(REG_KP_FORWARD, 24'd32768);
    reg_write(REG_KP_HEADING, 24'd13107);
    reg_write(REG_KI_HEADING, 24'd52);
    reg_write(REG_KD_HEADING, 24'd131072);
    reg_write(REG_KP_HEIGHT, 24'd65536);
    reg_write(REG_KI_HEIGHT, 24'd262);
    reg_write(REG_KD_HEIGHT, 24'd655360);
    reg_write(REG_ARRIVE_TOL, 24'd300);
    random_traffic(130);
    drain();

    $display("%0d beats in, %0d commands checked (turn %0d, move %0d, hold %0d)",
             beats_sent, commands_seen, phase_count[0], phase_count[1], phase_count[2]);
    $display("five gain settings, extremes included, %0d mismatches", errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
